// File: rtl/utf8_stream_decoder_core_defines.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8dec assertion failed");

// Next-cycle implication, checked outside reset.
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8dec assertion failed");

`endif

// File: rtl/u8dec_pkg.sv
package u8dec_pkg;

  localparam int unsigned CP_W = 21;
  localparam int unsigned PV_W = 31;
  localparam int unsigned REM_W = 3;
  localparam int unsigned KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_OK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOF = 2'd2;

  localparam logic [CP_W-1:0] ERR_CP = 21'h00FFFD;
  localparam logic [PV_W-1:0] MAX_CP = 31'h0010FFFF;

  typedef logic [KIND_W-1:0] kind_t;

  // Decoder state carried between items.
  typedef struct packed {
    logic [PV_W-1:0]  partial_value;
    logic [REM_W-1:0] bytes_remaining;
  } dec_state_t;

  // One optional result of a decode step.
  typedef struct packed {
    logic            vld;
    logic [CP_W-1:0] code_point;
    kind_t           kind;
  } dec_result_t;

  // Total sequence length of a lead byte, 0 for a bad lead.
  function automatic logic [REM_W-1:0] lead_length(input logic [7:0] b);
    logic [REM_W-1:0] len;
    priority casez (b)
      8'b0???????: len = 3'd1;
      8'b10??????: len = 3'd0;
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      8'b111110??: len = 3'd5;
      8'b1111110?: len = 3'd6;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  // Payload bits of a multi-byte lead byte.
  function automatic logic [6:0] lead_payload(input logic [7:0] b);
    logic [6:0] p;
    priority casez (b)
      8'b110?????: p = {2'b00, b[4:0]};
      8'b1110????: p = {3'b000, b[3:0]};
      8'b11110???: p = {4'b0000, b[2:0]};
      8'b111110??: p = {5'b00000, b[1:0]};
      8'b1111110?: p = {6'b000000, b[0]};
      default:     p = 7'd0;
    endcase
    return p;
  endfunction

  // Range, surrogate and noncharacter check on a completed value.
  function automatic logic value_ok(input logic [PV_W-1:0] v);
    logic bad;
    bad = (v > MAX_CP)
       || (v[15:1] == 15'h7FFF)
       || ((v >= 31'h0000D800) && (v <= 31'h0000DFFF))
       || ((v >= 31'h0000FDD0) && (v <= 31'h0000FDEF));
    return !bad;
  endfunction

endpackage

// File: rtl/u8dec_if.sv
// Byte channel: one byte or an end-of-file mark per item.
interface u8dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_marker;

  modport source (output valid, output byte_value, output end_marker, input ready);
  modport sink   (input valid, input byte_value, input end_marker, output ready);
endinterface

// Result channel: one decoded code point with its kind per item.
interface u8dec_cp_if;
  logic                          valid;
  logic                          ready;
  logic [u8dec_pkg::CP_W-1:0]    code_point;
  logic [u8dec_pkg::KIND_W-1:0]  result_kind;

  modport source (output valid, output code_point, output result_kind, input ready);
  modport sink   (input valid, input code_point, input result_kind, output ready);
endinterface

// File: rtl/u8dec_step.sv
// One decode step: current state plus one byte gives next state and an
// optional result.
module u8dec_step (
  input  u8dec_pkg::dec_state_t  state_i,
  input  logic [7:0]             byte_i,
  input  logic                   eof_i,
  output u8dec_pkg::dec_state_t  state_o,
  output u8dec_pkg::dec_result_t res_o
);

  logic [u8dec_pkg::REM_W-1:0] len;
  logic [u8dec_pkg::REM_W-1:0] rem_dec;
  logic [u8dec_pkg::PV_W-1:0]  shifted;
  logic                        is_cont;

  assign len     = u8dec_pkg::lead_length(byte_i);
  assign rem_dec = state_i.bytes_remaining - 3'd1;
  assign shifted = {state_i.partial_value[u8dec_pkg::PV_W-7:0], byte_i[5:0]};
  assign is_cont = (byte_i[7:6] == 2'b10);

  always_comb begin
    // Any result returns the decoder to idle.
    state_o         = '0;
    res_o.vld       = 1'b1;
    res_o.code_point = u8dec_pkg::ERR_CP;
    res_o.kind      = u8dec_pkg::KIND_ERR;
    if (state_i.bytes_remaining == '0) begin
      if (eof_i) begin
        res_o.code_point = '0;
        res_o.kind       = u8dec_pkg::KIND_EOF;
      end else if (len == 3'd1) begin
        res_o.code_point = {13'd0, byte_i};
        res_o.kind       = u8dec_pkg::KIND_OK;
      end else if (len != 3'd0) begin
        res_o.vld                = 1'b0;
        state_o.partial_value    = {24'd0, u8dec_pkg::lead_payload(byte_i)};
        state_o.bytes_remaining  = len - 3'd1;
      end
    end else if (!eof_i && is_cont) begin
      if (rem_dec != '0) begin
        res_o.vld               = 1'b0;
        state_o.partial_value   = shifted;
        state_o.bytes_remaining = rem_dec;
      end else if (u8dec_pkg::value_ok(shifted)) begin
        res_o.code_point = shifted[u8dec_pkg::CP_W-1:0];
        res_o.kind       = u8dec_pkg::KIND_OK;
      end
    end
  end

endmodule

// File: rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder core.
// in_ch carries one item per handshake: a raw byte, or an end-of-file mark
// when end_marker is set (byte_value is then ignored). out_ch carries zero or
// one result item per input item: a code point with result_kind 0 (valid),
// 1 (decoding error, code point 0xFFFD) or 2 (end of file, code point 0).
// A valid lead or continuation byte that does not yet complete a character gives no item.
// Both channels use valid/ready; an item moves when both are high.
// A result's last byte is held in the input register; the decode step then
// loads the result register from it once the result register is empty or
// out_ch is ready.
// Throughput: one byte per cycle while out_ch does not stall, set by the
// single decode step that reads the input register and the partial-value
// state and writes the result register in the same cycle.
// Reset (rst_n low, synchronous) empties both registers and puts the decoder
// idle with no partial value.
// When the receiver stalls, the result register holds its item and the input
// register takes one more byte; in_ch.ready then drops until out_ch moves.
`include "utf8_stream_decoder_core_defines.svh"

module utf8_stream_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  u8dec_byte_if.sink          in_ch,
  u8dec_cp_if.source          out_ch
);

  // Input register
  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_eof_r;

  // Decoder state
  u8dec_pkg::dec_state_t  state_r;
  u8dec_pkg::dec_state_t  state_nxt;
  u8dec_pkg::dec_state_t  step_state;
  u8dec_pkg::dec_result_t step_res;

  // Result register
  logic                          out_vld_r;
  logic                          out_vld_nxt;
  logic [u8dec_pkg::CP_W-1:0]    out_cp_r;
  u8dec_pkg::kind_t              out_kind_r;

  logic adv;     // the byte in the input register is decoded this cycle
  logic in_acc;

  assign adv    = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_vld_r || adv;

  u8dec_step u_step (
    .state_i (state_r),
    .byte_i  (in_byte_r),
    .eof_i   (in_eof_r),
    .state_o (step_state),
    .res_o   (step_res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ch.ready) begin
      in_vld_nxt = in_ch.valid;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      state_nxt   = step_state;
      out_vld_nxt = step_res.vld;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      state_r   <= state_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_ch.byte_value;
      in_eof_r  <= in_ch.end_marker;
    end
    if (adv && step_res.vld) begin
      out_cp_r   <= step_res.code_point;
      out_kind_r <= step_res.kind;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.code_point  = out_cp_r;
  assign out_ch.result_kind = out_kind_r;

  // At most five continuation bytes are ever pending.
  `U8D_ASSERT_NOW(a_rem_range, clk, rst_n, 1'b1, state_r.bytes_remaining <= 3'd5)
  // Every emitted result leaves the decoder idle and cleared.
  `U8D_ASSERT_NEXT(a_idle_after_result, clk, rst_n, adv && step_res.vld,
                   (state_r.bytes_remaining == 3'd0) && (state_r.partial_value == '0))
  // End-of-file results carry code point zero; errors carry 0xFFFD.
  `U8D_ASSERT_NOW(a_eof_zero, clk, rst_n,
                  out_vld_r && (out_kind_r == u8dec_pkg::KIND_EOF), out_cp_r == '0)
  `U8D_ASSERT_NOW(a_err_cp, clk, rst_n,
                  out_vld_r && (out_kind_r == u8dec_pkg::KIND_ERR),
                  out_cp_r == u8dec_pkg::ERR_CP)

endmodule
